// ===== design/css_pkg.sv =====
package css_pkg;

  // Geometry of the block
  localparam int MAX_ENTITIES = 256;
  localparam int NUM_TYPES    = 8;
  localparam int CAPACITY     = 256;
  localparam int DATA_W       = 32;

  localparam int ENT_W  = $clog2(MAX_ENTITIES);
  localparam int TYPE_W = $clog2(NUM_TYPES);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W  = ENT_W + TYPE_W;
  localparam int SADR_W = TYPE_W + SLOT_W;
  localparam int SLOT_ENTRY_W = ENT_W + DATA_W;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_RSLOT  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_OWNED     = 3'd1,
    ST_NOT_OWNED = 3'd2,
    ST_FULL      = 3'd3,
    ST_BEYOND    = 3'd4
  } status_t;

  // Source of the dense-slot read address
  typedef enum logic [1:0] {
    SS_NONE  = 2'd0,
    SS_LAST  = 2'd1,
    SS_FIELD = 2'd2,
    SS_IDX   = 2'd3
  } slot_src_t;

  // Commit action of the final step
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_LOOKUP = 3'd3,
    ACT_RSLOT  = 3'd4
  } act_t;

  // Sequencing of the step counter
  typedef enum logic [1:0] {
    SQ_NEXT     = 2'd0,
    SQ_DISPATCH = 2'd1,
    SQ_END      = 2'd2
  } seq_t;

  typedef struct packed {
    logic      rd_key;
    slot_src_t src;
    act_t      act;
    seq_t      seq;
  } uword_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic      ld;
    logic      rd_key;
    slot_src_t src;
    act_t      act;
    logic      commit;
  } ctl_t;

  typedef struct packed {
    status_t           status;
    logic              present;
    logic [DATA_W-1:0] value;
    logic [ENT_W-1:0]  holder;
    logic [CNT_W-1:0]  count;
  } res_t;

  // Microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] U_ADD_RD  = 4'd1;
  localparam logic [UPC_W-1:0] U_ADD_WR  = 4'd2;
  localparam logic [UPC_W-1:0] U_REM_RD  = 4'd3;
  localparam logic [UPC_W-1:0] U_REM_WR  = 4'd4;
  localparam logic [UPC_W-1:0] U_LK_RD   = 4'd5;
  localparam logic [UPC_W-1:0] U_LK_SLOT = 4'd6;
  localparam logic [UPC_W-1:0] U_LK_OUT  = 4'd7;
  localparam logic [UPC_W-1:0] U_RS_RD   = 4'd8;
  localparam logic [UPC_W-1:0] U_RS_OUT  = 4'd9;

  function automatic uword_t ucode(input logic [UPC_W-1:0] a);
    uword_t w;
    w = '{rd_key: 1'b0, src: SS_NONE, act: ACT_NONE, seq: SQ_NEXT};
    unique case (a)
      U_IDLE:    w.seq = SQ_DISPATCH;
      U_ADD_RD:  w.rd_key = 1'b1;
      U_ADD_WR: begin
        w.act = ACT_ADD;
        w.seq = SQ_END;
      end
      U_REM_RD: begin
        w.rd_key = 1'b1;
        w.src    = SS_LAST;
      end
      U_REM_WR: begin
        w.act = ACT_REMOVE;
        w.seq = SQ_END;
      end
      U_LK_RD:   w.rd_key = 1'b1;
      U_LK_SLOT: w.src = SS_IDX;
      U_LK_OUT: begin
        w.act = ACT_LOOKUP;
        w.seq = SQ_END;
      end
      U_RS_RD: begin
        w.rd_key = 1'b1;
        w.src    = SS_FIELD;
      end
      U_RS_OUT: begin
        w.act = ACT_RSLOT;
        w.seq = SQ_END;
      end
      default:   w.seq = SQ_END;
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry(input op_t op);
    logic [UPC_W-1:0] a;
    unique case (op)
      OP_ADD:    a = U_ADD_RD;
      OP_REMOVE: a = U_REM_RD;
      OP_LOOKUP: a = U_LK_RD;
      OP_RSLOT:  a = U_RS_RD;
      default:   a = U_IDLE;
    endcase
    return a;
  endfunction

endpackage

// ===== design/css_ram.sv =====
module css_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/css_seq.sv =====
module css_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [css_pkg::OP_W-1:0] op,
  output logic               req_stall,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  output css_pkg::ctl_t      ctl
);

  logic [css_pkg::UPC_W-1:0] upc;
  logic [css_pkg::UPC_W-1:0] upc_next;
  css_pkg::uword_t           uw;
  logic                      emit;
  logic                      hold;
  logic                      accept;

  assign uw   = css_pkg::ucode(upc);
  assign emit = (uw.act != css_pkg::ACT_NONE);
  // Hold the final step while the output register is still full and stalled
  assign hold = emit && rsp_valid && rsp_stall;

  assign req_stall = (uw.seq != css_pkg::SQ_DISPATCH);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    upc_next = upc;
    unique case (uw.seq)
      css_pkg::SQ_DISPATCH: begin
        if (req_valid) begin
          upc_next = css_pkg::entry(css_pkg::op_t'(op));
        end
      end
      css_pkg::SQ_NEXT: upc_next = upc + css_pkg::UPC_W'(1);
      css_pkg::SQ_END: begin
        if (!hold) begin
          upc_next = css_pkg::U_IDLE;
        end
      end
      default: upc_next = css_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= css_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctl = '{ld: accept, rd_key: uw.rd_key, src: uw.src, act: uw.act,
                 commit: emit && !hold};

endmodule

// ===== design/css_dpath.sv =====
module css_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  css_pkg::ctl_t                   ctl,
  input  logic [css_pkg::ENT_W-1:0]       entity,
  input  logic [css_pkg::TYPE_W-1:0]      ctype,
  input  logic [css_pkg::DATA_W-1:0]      payload,
  input  logic [css_pkg::SLOT_W-1:0]      slot,
  output css_pkg::res_t                   res
);

  logic [css_pkg::ENT_W-1:0]  ent_q;
  logic [css_pkg::TYPE_W-1:0] ct_q;
  logic [css_pkg::DATA_W-1:0] pay_q;
  logic [css_pkg::SLOT_W-1:0] slot_q;

  logic [css_pkg::CNT_W-1:0]        cnt [css_pkg::NUM_TYPES];
  logic [css_pkg::CNT_W-1:0]        cnt_next;
  logic [css_pkg::MAX_ENTITIES-1:0] row_vld;
  logic                             row_vld_q;

  logic [css_pkg::NUM_TYPES-1:0]    own_rdata;
  logic [css_pkg::NUM_TYPES-1:0]    row;
  logic [css_pkg::NUM_TYPES-1:0]    row_new;
  logic [css_pkg::NUM_TYPES-1:0]    type_bit;
  logic                             own_we;

  logic [css_pkg::SLOT_W-1:0]       idx_rdata;
  logic [css_pkg::KEY_W-1:0]        idx_waddr;
  logic [css_pkg::SLOT_W-1:0]       idx_wdata;
  logic                             idx_we;

  logic [css_pkg::SLOT_ENTRY_W-1:0] sl_rdata;
  logic [css_pkg::SLOT_ENTRY_W-1:0] sl_wdata;
  logic [css_pkg::SADR_W-1:0]       sl_waddr;
  logic [css_pkg::SLOT_W-1:0]       sl_ra;
  logic                             sl_re;
  logic                             sl_we;

  logic [css_pkg::CNT_W-1:0]  n;
  logic [css_pkg::CNT_W-1:0]  last;
  logic                       owns;
  logic                       own;
  logic                       add_ok;
  logic                       rem_ok;
  logic                       moved;
  logic [css_pkg::ENT_W-1:0]  mover;

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      ent_q  <= entity;
      ct_q   <= ctype;
      pay_q  <= payload;
      slot_q <= slot;
    end
    if (ctl.rd_key) begin
      row_vld_q <= row_vld[ent_q];
    end
  end

  assign n        = cnt[ct_q];
  assign last     = n - css_pkg::CNT_W'(1);
  assign type_bit = css_pkg::NUM_TYPES'(1) << ct_q;
  assign row      = row_vld_q ? own_rdata : '0;
  assign owns     = |(row & type_bit);
  assign own      = owns && ({1'b0, idx_rdata} < n);
  assign add_ok   = !own && (n < css_pkg::CNT_W'(css_pkg::CAPACITY));
  assign rem_ok   = own;
  assign moved    = ({1'b0, idx_rdata} != last);
  assign mover    = sl_rdata[css_pkg::SLOT_ENTRY_W-1 -: css_pkg::ENT_W];

  // Present bits, one row of types per entity
  assign own_we  = ctl.commit &&
                   ((ctl.act == css_pkg::ACT_ADD && add_ok) ||
                    (ctl.act == css_pkg::ACT_REMOVE && rem_ok));
  assign row_new = (ctl.act == css_pkg::ACT_ADD) ? (row | type_bit) : (row & ~type_bit);

  css_ram #(.W(css_pkg::NUM_TYPES), .D(css_pkg::MAX_ENTITIES)) u_own (
    .clk   (clk),
    .we    (own_we),
    .waddr (ent_q),
    .wdata (row_new),
    .re    (ctl.rd_key),
    .raddr (ent_q),
    .rdata (own_rdata)
  );

  // Slot index per (entity, type); on remove repoint the moved owner
  always_comb begin
    idx_we    = 1'b0;
    idx_waddr = {ent_q, ct_q};
    idx_wdata = n[css_pkg::SLOT_W-1:0];
    if (ctl.commit && ctl.act == css_pkg::ACT_ADD && add_ok) begin
      idx_we = 1'b1;
    end else if (ctl.commit && ctl.act == css_pkg::ACT_REMOVE && rem_ok && moved) begin
      idx_we    = 1'b1;
      idx_waddr = {mover, ct_q};
      idx_wdata = idx_rdata;
    end
  end

  css_ram #(.W(css_pkg::SLOT_W), .D(css_pkg::MAX_ENTITIES * css_pkg::NUM_TYPES)) u_idx (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .re    (ctl.rd_key),
    .raddr ({ent_q, ct_q}),
    .rdata (idx_rdata)
  );

  // Dense slots: owner and data side by side
  always_comb begin
    sl_re = 1'b1;
    sl_ra = slot_q;
    unique case (ctl.src)
      css_pkg::SS_NONE:  sl_re = 1'b0;
      css_pkg::SS_LAST:  sl_ra = last[css_pkg::SLOT_W-1:0];
      css_pkg::SS_FIELD: sl_ra = slot_q;
      css_pkg::SS_IDX:   sl_ra = idx_rdata;
      default:           sl_re = 1'b0;
    endcase
  end

  always_comb begin
    sl_we    = 1'b0;
    sl_waddr = {ct_q, n[css_pkg::SLOT_W-1:0]};
    sl_wdata = {ent_q, pay_q};
    if (ctl.commit && ctl.act == css_pkg::ACT_ADD && add_ok) begin
      sl_we = 1'b1;
    end else if (ctl.commit && ctl.act == css_pkg::ACT_REMOVE && rem_ok && moved) begin
      sl_we    = 1'b1;
      sl_waddr = {ct_q, idx_rdata};
      sl_wdata = sl_rdata;
    end
  end

  css_ram #(.W(css_pkg::SLOT_ENTRY_W), .D(css_pkg::NUM_TYPES * css_pkg::CAPACITY)) u_slot (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .re    (sl_re),
    .raddr ({ct_q, sl_ra}),
    .rdata (sl_rdata)
  );

  // Result of the final step
  always_comb begin
    cnt_next = n;
    res      = '{status: css_pkg::ST_OK, present: owns, value: '0, holder: '0, count: n};
    unique case (ctl.act)
      css_pkg::ACT_ADD: begin
        if (own) begin
          res.status = css_pkg::ST_OWNED;
        end else if (!add_ok) begin
          res.status = css_pkg::ST_FULL;
        end else begin
          res.present = 1'b1;
          cnt_next    = n + css_pkg::CNT_W'(1);
        end
      end
      css_pkg::ACT_REMOVE: begin
        if (!rem_ok) begin
          res.status = css_pkg::ST_NOT_OWNED;
        end else begin
          res.present = 1'b0;
          cnt_next    = last;
        end
      end
      css_pkg::ACT_LOOKUP: begin
        if (!own) begin
          res.status = css_pkg::ST_NOT_OWNED;
        end else begin
          res.value  = sl_rdata[css_pkg::DATA_W-1:0];
          res.holder = ent_q;
        end
      end
      css_pkg::ACT_RSLOT: begin
        if ({1'b0, slot_q} >= n) begin
          res.status = css_pkg::ST_BEYOND;
        end else begin
          res.value  = sl_rdata[css_pkg::DATA_W-1:0];
          res.holder = mover;
        end
      end
      default: res.status = css_pkg::ST_OK;
    endcase
    res.count = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < css_pkg::NUM_TYPES; i++) begin
        cnt[i] <= '0;
      end
      row_vld <= '0;
    end else begin
      if (ctl.commit) begin
        cnt[ct_q] <= cnt_next;
      end
      if (own_we) begin
        row_vld[ent_q] <= 1'b1;
      end
    end
  end

endmodule

// ===== design/component_sparse_set_top.sv =====
// A result is registered on the final step of the request's program (lookup adds a slot read).
// A new request is taken only once the program is back at its idle step, never overlapped;
//   each step waits on the registered read of the present, index and slot memories.
// Reset: clears the step counter, the per-type counts, the per-entity row-valid bits and
//   the result valid; no clearing pass, so requests are taken as soon as reset is released.
module component_sparse_set_top (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [css_pkg::OP_W-1:0]        op,
  input  logic [css_pkg::ENT_W-1:0]       entity,
  input  logic [css_pkg::TYPE_W-1:0]      ctype,
  input  logic [css_pkg::DATA_W-1:0]      payload,
  input  logic [css_pkg::SLOT_W-1:0]      slot,
  // Response channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [css_pkg::STAT_W-1:0]      status,
  output logic                            present,
  output logic [css_pkg::DATA_W-1:0]      value,
  output logic [css_pkg::ENT_W-1:0]       holder,
  output logic [css_pkg::CNT_W-1:0]       count
);

  css_pkg::ctl_t ctl;
  css_pkg::res_t res;
  css_pkg::res_t rsp_q;

  // Step counter and control store: dispatch on op, then walk the short program
  css_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .op        (op),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  // Memories, counts and result logic
  css_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .entity  (entity),
    .ctype   (ctype),
    .payload (payload),
    .slot    (slot),
    .res     (res)
  );

  // Output register: load on the final step, drop valid once the transfer completes.
  // The sequencer holds its final step while this register is still occupied and stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp_q <= res;
    end
  end

  assign status  = rsp_q.status;
  assign present = rsp_q.present;
  assign value   = rsp_q.value;
  assign holder  = rsp_q.holder;
  assign count   = rsp_q.count;

endmodule
